/* design/assert_macros.svh */
// Assertion macros shared by the arc-length interpolator RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check, sampled on clk, off while reset is asserted.
`define AP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true.
`define AP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/alpi_pkg.sv */
// Shared types and constants for the arc-length path interpolator.
// No dependencies; imported by alpi_mem, alpi_iter and the top level.
package alpi_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam int FRAC_BITS  = 24;
    localparam int DIV_STEPS  = 24;
    localparam int SQRT_STEPS = 32;
    localparam logic [23:0] FRAC_HALF = 24'h80_0000;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [31:0] tstamp;
        logic [31:0] speed;
        logic [31:0] turn;
        logic [31:0] len;
    } pt_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_APP_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_SQRT,
        ST_APP_WR,
        ST_Q_SCAN,
        ST_FETCH_ISS,
        ST_FETCH_I,
        ST_FETCH_Q,
        ST_FETCH_P,
        ST_DIV_GO,
        ST_DIV,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_END,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        FLD_X,
        FLD_Y,
        FLD_SPEED,
        FLD_TURN,
        FLD_TIME,
        FLD_HEAD
    } lerp_fld_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

endpackage

/* design/alpi_mem.sv */
// Point table: one write port, one registered read port.
// Depends on alpi_pkg (pt_t).
module alpi_mem import alpi_pkg::*; #(
    parameter int DEPTH = MAX_POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pt_t                      wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output pt_t                      rd_data
);

    pt_t mem [DEPTH];
    pt_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/alpi_mul.sv */
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing but the clock.
module alpi_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* design/alpi_iter.sv */
// Shared compare-subtract unit: restoring divide (24 quotient bits) or
// 64-bit floor integer square root (32 steps). Depends on alpi_pkg.
`include "assert_macros.svh"

module alpi_iter import alpi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  iter_req_t   req,
    input  logic [63:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    iter_op_t    op_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] den_reg;

    logic [64:0] cand;
    logic [64:0] sub;
    logic [65:0] diff;
    logic        ge;

    // divide shifts the remainder up; root compares against res + bit
    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            cand = {acc_reg, 1'b0};
            sub  = {33'd0, den_reg};
        end
        else
        begin
            cand = {1'b0, acc_reg};
            sub  = {1'b0, res_reg + bit_reg};
        end
        diff = {1'b0, cand} - {1'b0, sub};
        ge   = !diff[65];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_DIV) ? 5'(DIV_STEPS - 1) : 5'(SQRT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= opa;
            den_reg <= opb;
            res_reg <= '0;
            bit_reg <= SQRT_BIT0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                acc_reg <= ge ? diff[63:0] : cand[63:0];
                res_reg <= {res_reg[62:0], ge};
            end
            else
            begin
                acc_reg <= ge ? diff[63:0] : acc_reg;
                res_reg <= ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done   = done_reg;
    assign result = res_reg[31:0];

    `AP_CHECK(a_rem_below_den, busy_reg && op_reg == OP_DIV |-> acc_reg < 64'(den_reg), "divide remainder not below divisor")
    `AP_CHECK(a_done_single, done_reg |=> !done_reg, "done held longer than one cycle")
    `AP_NEVER(a_start_when_busy, req.start && busy_reg, "unit restarted while busy")

endmodule

/* design/arc_length_path_interpolator.sv */
// Arc-length path interpolator top level: sequencer, point table, shared units.
// Depends on alpi_pkg, alpi_mem, alpi_mul, alpi_iter and assert_macros.svh.
//
// Usage: one input channel (item_valid / item_stall) carries a mode and one point
// or a query length; one output channel (result_valid / result_stall) returns
// exactly one result per input transfer, in order.
// Mode start writes point 0 and restarts the path; append adds a point and its
// cumulative arc length (squares on the shared multiplier, 32-step square root
// on the shared compare-subtract unit); query scans the stored lengths one entry
// per cycle, divides for the segment fraction (24 steps) and interpolates six
// fields on the multiplier.
// Start, a full table and the unused mode 3 finish with no further work; a query
// with query_s at or past the last point returns that point's fields unblended.
// One item is in flight at a time; item_stall is high while it is worked on.
// A finished result sits in the output register; the next item is accepted
// while it waits, but that item completes only after the receiver takes it.
// Reset empties the path (point count zero); the table needs no clearing pass.
`include "assert_macros.svh"

module arc_length_path_interpolator import alpi_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [15:0] point_heading,
    input  logic [31:0] point_time,
    input  logic [31:0] point_speed,
    input  logic [31:0] point_turn_rate,
    input  logic [31:0] query_s,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [15:0] heading,
    output logic [31:0] speed,
    output logic [31:0] turn_rate,
    output logic [31:0] time_at,
    output logic [7:0]  segment_index,
    output logic [31:0] total_length
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic [31:0]     total_reg;

    pt_t             pnt_reg, a_reg, b_reg;
    logic [15:0]     hprev_reg;
    logic [31:0]     s_reg;
    logic [IW-1:0]   i_reg, k_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [63:0]     sq_reg;
    logic [31:0]     seg_reg;
    logic [23:0]     w_reg;
    lerp_fld_t       fld_reg;

    logic [1:0]      r_status;
    logic [31:0]     r_x, r_y, r_speed, r_turn, r_time, r_total;
    logic [15:0]     r_head;
    logic [IW-1:0]   r_idx;

    logic            result_valid_reg;
    logic [1:0]      status_reg;
    logic [31:0]     pos_x_reg, pos_y_reg, speed_reg, turn_rate_reg, time_at_reg;
    logic [31:0]     total_length_reg;
    logic [15:0]     heading_reg;
    logic [7:0]      segment_index_reg;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr, mem_raddr;
    pt_t             mem_wdata, mem_rdata;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    iter_req_t       ireq;
    logic [63:0]     iter_a;
    logic [31:0]     iter_b;
    logic            iter_done;
    logic [31:0]     iter_res;

    logic            accept;
    logic            slot_free;
    logic [CW-1:0]   cnt_m1;
    logic [IW-1:0]   last_idx;
    logic [IW-1:0]   scan_c;
    logic            scan_last;
    logic            i_last;
    logic            full;
    logic            len_le_s;
    logic [31:0]     s_clamp;
    logic [64:0]     sum65;
    logic [32:0]     tot33;
    logic [31:0]     tot;
    logic [15:0]     hd_tgt;
    logic [23:0]     hd_wt;
    logic [31:0]     base32;
    logic signed [32:0] diff33;
    logic [23:0]     wt24;
    logic [31:0]     lerp_val;
    logic [IW+7:0]   idx_wide;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign slot_free  = !result_valid_reg || !result_stall;

    assign cnt_m1    = count_reg - 1'b1;
    assign last_idx  = cnt_m1[IW-1:0];
    assign scan_c    = k_reg - 1'b1;
    assign scan_last = ({1'b0, scan_c} == cnt_m1);
    assign i_last    = ({1'b0, i_reg} == cnt_m1);
    assign full      = (count_reg == CW'(MAX_POINTS));
    assign len_le_s  = (mem_rdata.len <= s_reg);
    assign s_clamp   = query_s[31] ? 32'd0 : query_s;
    assign sum65     = {1'b0, sq_reg} + {1'b0, mul_p[63:0]};
    assign tot33     = {1'b0, total_reg} + {1'b0, seg_reg};
    assign tot       = tot33[32] ? 32'hFFFF_FFFF : tot33[31:0];

    // past segment 0, heading blends toward the previous point in the first half
    always_comb
    begin
        if (i_reg == '0)
        begin
            hd_tgt = b_reg.heading;
            hd_wt  = w_reg;
        end
        else if (w_reg < FRAC_HALF)
        begin
            hd_tgt = hprev_reg;
            hd_wt  = FRAC_HALF - w_reg;
        end
        else
        begin
            hd_tgt = b_reg.heading;
            hd_wt  = w_reg - FRAC_HALF;
        end
    end

    always_comb
    begin
        wt24 = w_reg;
        case (fld_reg)
            FLD_X:
            begin
                base32 = a_reg.x;
                diff33 = {b_reg.x[31], b_reg.x} - {a_reg.x[31], a_reg.x};
            end
            FLD_Y:
            begin
                base32 = a_reg.y;
                diff33 = {b_reg.y[31], b_reg.y} - {a_reg.y[31], a_reg.y};
            end
            FLD_SPEED:
            begin
                base32 = a_reg.speed;
                diff33 = {b_reg.speed[31], b_reg.speed} - {a_reg.speed[31], a_reg.speed};
            end
            FLD_TURN:
            begin
                base32 = a_reg.turn;
                diff33 = {b_reg.turn[31], b_reg.turn} - {a_reg.turn[31], a_reg.turn};
            end
            FLD_TIME:
            begin
                base32 = a_reg.tstamp;
                diff33 = {1'b0, b_reg.tstamp} - {1'b0, a_reg.tstamp};
            end
            FLD_HEAD:
            begin
                base32 = {{16{a_reg.heading[15]}}, a_reg.heading};
                diff33 = {{17{hd_tgt[15]}}, hd_tgt} - {{17{a_reg.heading[15]}}, a_reg.heading};
                wt24   = hd_wt;
            end
            default:
            begin
                base32 = a_reg.x;
                diff33 = '0;
            end
        endcase
    end

    // a + floor(d*w / 2^24); only the low bits survive
    assign lerp_val = base32 + mul_p[55:24];

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[IW-1:0];
        mem_wdata  = pnt_reg;
        mem_wdata.len = tot;
        mem_raddr  = i_reg;
        mul_a      = diff33;
        mul_b      = {9'd0, wt24};
        ireq.start = 1'b0;
        ireq.op    = OP_DIV;
        iter_a     = {32'd0, s_reg - a_reg.len};
        iter_b     = b_reg.len - a_reg.len;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    case (mode)
                        MODE_START:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = {point_x, point_y, point_heading, point_time,
                                         point_speed, point_turn_rate, 32'd0};
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg == '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {point_x, point_y, point_heading, point_time,
                                             point_speed, point_turn_rate, 32'd0};
                            end
                            else if (!full)
                            begin
                                mem_raddr  = last_idx;
                                state_next = ST_APP_DIFF;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (count_reg == CW'(1))
                            begin
                                state_next = ST_FETCH_ISS;
                            end
                            else if (count_reg != '0)
                            begin
                                mem_raddr  = IW'(1);
                                state_next = ST_Q_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_APP_DIFF:
            begin
                state_next = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                mul_a      = dx_reg;
                mul_b      = dx_reg;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                mul_a      = dy_reg;
                mul_b      = dy_reg;
                state_next = ST_SQ_SUM;
            end
            ST_SQ_SUM:
            begin
                if (sum65[64])
                begin
                    state_next = ST_APP_WR;
                end
                else
                begin
                    ireq.start = 1'b1;
                    ireq.op    = OP_SQRT;
                    iter_a     = sum65[63:0];
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (iter_done)
                begin
                    state_next = ST_APP_WR;
                end
            end
            ST_APP_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_Q_SCAN:
            begin
                if (len_le_s && !scan_last)
                begin
                    mem_raddr = k_reg;
                end
                else
                begin
                    state_next = ST_FETCH_ISS;
                end
            end
            ST_FETCH_ISS:
            begin
                state_next = ST_FETCH_I;
            end
            ST_FETCH_I:
            begin
                if (i_last)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    mem_raddr  = i_reg + 1'b1;
                    state_next = ST_FETCH_Q;
                end
            end
            ST_FETCH_Q:
            begin
                if (i_reg != '0)
                begin
                    mem_raddr  = i_reg - 1'b1;
                    state_next = ST_FETCH_P;
                end
                else
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_FETCH_P:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                ireq.start = 1'b1;
                ireq.op    = OP_DIV;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (iter_done)
                begin
                    state_next = ST_LERP_MUL;
                end
            end
            ST_LERP_MUL:
            begin
                state_next = ST_LERP_ADD;
            end
            ST_LERP_ADD:
            begin
                state_next = (fld_reg == FLD_HEAD) ? ST_DONE : ST_LERP_MUL;
            end
            ST_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (mode == MODE_START || (mode == MODE_APPEND && count_reg == '0)))
            begin
                count_reg <= CW'(1);
                total_reg <= '0;
            end
            else if (state_reg == ST_APP_WR)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= tot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    r_status <= STAT_OK;
                    r_x      <= '0;
                    r_y      <= '0;
                    r_head   <= '0;
                    r_speed  <= '0;
                    r_turn   <= '0;
                    r_time   <= '0;
                    r_idx    <= '0;
                    r_total  <= '0;
                    pnt_reg  <= {point_x, point_y, point_heading, point_time,
                                 point_speed, point_turn_rate, 32'd0};
                    s_reg    <= s_clamp;
                    i_reg    <= '0;
                    k_reg    <= IW'(2);
                    case (mode)
                        MODE_APPEND:
                        begin
                            if (count_reg != '0 && full)
                            begin
                                r_status <= STAT_FULL;
                                r_idx    <= last_idx;
                                r_total  <= total_reg;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                r_status <= STAT_EMPTY;
                            end
                        end
                        MODE_START:
                        begin
                            r_idx <= '0;
                        end
                        default:
                        begin
                            if (count_reg != '0)
                            begin
                                r_idx   <= last_idx;
                                r_total <= total_reg;
                            end
                        end
                    endcase
                end
            end
            ST_APP_DIFF:
            begin
                dx_reg <= {pnt_reg.x[31], pnt_reg.x} - {mem_rdata.x[31], mem_rdata.x};
                dy_reg <= {pnt_reg.y[31], pnt_reg.y} - {mem_rdata.y[31], mem_rdata.y};
            end
            ST_SQ_Y:
            begin
                sq_reg <= mul_p[63:0];
            end
            ST_SQ_SUM:
            begin
                seg_reg <= 32'hFFFF_FFFF;
            end
            ST_SQRT:
            begin
                if (iter_done)
                begin
                    seg_reg <= iter_res;
                end
            end
            ST_APP_WR:
            begin
                r_idx   <= count_reg[IW-1:0];
                r_total <= tot;
            end
            ST_Q_SCAN:
            begin
                if (len_le_s)
                begin
                    i_reg <= scan_c;
                    k_reg <= k_reg + 1'b1;
                end
            end
            ST_FETCH_I:
            begin
                a_reg <= mem_rdata;
            end
            ST_FETCH_Q:
            begin
                b_reg <= mem_rdata;
            end
            ST_FETCH_P:
            begin
                hprev_reg <= mem_rdata.heading;
            end
            ST_DIV:
            begin
                w_reg   <= iter_res[23:0];
                fld_reg <= FLD_X;
            end
            ST_LERP_ADD:
            begin
                case (fld_reg)
                    FLD_X:     r_x     <= lerp_val;
                    FLD_Y:     r_y     <= lerp_val;
                    FLD_SPEED: r_speed <= lerp_val;
                    FLD_TURN:  r_turn  <= lerp_val;
                    FLD_TIME:  r_time  <= lerp_val;
                    FLD_HEAD:  r_head  <= lerp_val[15:0];
                    default:   r_x     <= lerp_val;
                endcase
                fld_reg <= lerp_fld_t'(3'(fld_reg + 3'd1));
                r_idx   <= i_reg;
                r_total <= total_reg;
            end
            ST_END:
            begin
                r_x     <= a_reg.x;
                r_y     <= a_reg.y;
                r_head  <= a_reg.heading;
                r_speed <= a_reg.speed;
                r_turn  <= a_reg.turn;
                r_time  <= a_reg.tstamp;
                r_idx   <= i_reg;
                r_total <= total_reg;
            end
            default:
            begin
                r_status <= r_status;
            end
        endcase
    end

    assign idx_wide = {8'd0, r_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && slot_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && slot_free)
        begin
            status_reg        <= r_status;
            pos_x_reg         <= r_x;
            pos_y_reg         <= r_y;
            heading_reg       <= r_head;
            speed_reg         <= r_speed;
            turn_rate_reg     <= r_turn;
            time_at_reg       <= r_time;
            segment_index_reg <= idx_wide[7:0];
            total_length_reg  <= r_total;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign heading       = heading_reg;
    assign speed         = speed_reg;
    assign turn_rate     = turn_rate_reg;
    assign time_at       = time_at_reg;
    assign segment_index = segment_index_reg;
    assign total_length  = total_length_reg;

    alpi_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    alpi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    alpi_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ireq),
        .opa    (iter_a),
        .opb    (iter_b),
        .done   (iter_done),
        .result (iter_res)
    );

    `AP_CHECK(a_count_bound, count_reg <= CW'(MAX_POINTS), "point count past table size")
    `AP_CHECK(a_empty_len, count_reg == '0 |-> total_reg == '0, "empty path with nonzero length")
    `AP_CHECK(a_result_from_done, $rose(result_valid_reg) |-> $past(state_reg == ST_DONE), "result raised outside completion")

endmodule
